@@ rtl/tcpo_pkg.sv @@
`timescale 1ns / 1ps
// Package for the TCP option parser: option kind codes, limits and the
// request and summary structures. Depends on nothing.

package tcpo_pkg;

    localparam int MAX_SACK_BLOCKS  = 4;
    localparam int MAX_OPTION_BYTES = 40;

    localparam int VALUE_BYTES = 8;
    localparam int ACC_W       = $clog2(VALUE_BYTES + 1);
    localparam int AREA_W      = $clog2(MAX_OPTION_BYTES + 1);

    localparam logic [7:0] KIND_NOP        = 8'd1;
    localparam logic [7:0] KIND_MSS        = 8'd2;
    localparam logic [7:0] KIND_WSCALE     = 8'd3;
    localparam logic [7:0] KIND_SACK_OK    = 8'd4;
    localparam logic [7:0] KIND_SACK       = 8'd5;
    localparam logic [7:0] KIND_ECHO       = 8'd6;
    localparam logic [7:0] KIND_ECHO_REPLY = 8'd7;
    localparam logic [7:0] KIND_TIMESTAMP  = 8'd8;
    localparam logic [7:0] KIND_CC         = 8'd11;
    localparam logic [7:0] KIND_CC_NEW     = 8'd12;
    localparam logic [7:0] KIND_CC_ECHO    = 8'd13;

    localparam logic [7:0] SACK_HDR_BYTES  = 8'd2;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       captured;
        logic       area_end;
        logic       area_empty;
    } opt_req_t;

    typedef struct packed {
        logic     valid;
        opt_req_t req;
    } opt_slot_t;

    typedef struct packed {
        logic [15:0] mss_value;
        logic        mss_seen;
        logic [7:0]  wscale_value;
        logic        wscale_seen;
        logic [31:0] ts_value;
        logic [31:0] ts_echo;
        logic        ts_seen;
        logic        sack_permitted;
        logic [2:0]  sack_blocks;
        logic        sack_seen;
        logic [5:0]  unknown_options;
        logic        truncated;
    } opt_sum_t;

endpackage

@@ rtl/tcpo_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the TCP option parser: option bytes in, summaries out.
// Valid/ready handshake; no dependencies.

interface tcpo_opt_if;
    logic       valid;
    logic       ready;
    logic [7:0] opt_byte;
    logic       captured;
    logic       area_end;
    logic       area_empty;

    modport source (output valid, output opt_byte, output captured, output area_end,
                    output area_empty, input ready);
    modport sink (input valid, input opt_byte, input captured, input area_end,
                  input area_empty, output ready);
endinterface

interface tcpo_sum_if;
    logic        valid;
    logic        ready;
    logic [15:0] mss_value;
    logic        mss_seen;
    logic [7:0]  wscale_value;
    logic        wscale_seen;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic        ts_seen;
    logic        sack_permitted;
    logic [2:0]  sack_blocks;
    logic        sack_seen;
    logic [5:0]  unknown_options;
    logic        truncated;

    modport source (output valid, output mss_value, output mss_seen, output wscale_value,
                    output wscale_seen, output ts_value, output ts_echo, output ts_seen,
                    output sack_permitted, output sack_blocks, output sack_seen,
                    output unknown_options, output truncated, input ready);
    modport sink (input valid, input mss_value, input mss_seen, input wscale_value,
                  input wscale_seen, input ts_value, input ts_echo, input ts_seen,
                  input sack_permitted, input sack_blocks, input sack_seen,
                  input unknown_options, input truncated, output ready);
endinterface

@@ rtl/tcpo_in_stage.sv @@
`timescale 1ns / 1ps
// Input register of the TCP option parser: holds one option byte request.
// Depends on tcpo_pkg and tcpo_opt_if.

module tcpo_in_stage
    import tcpo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tcpo_opt_if.sink     opt,
    input  logic         step,
    output opt_slot_t    slot
);

    logic     valid_reg;
    opt_req_t req_reg;

    assign opt.ready = !valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (opt.ready)
        begin
            valid_reg <= opt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (opt.valid && opt.ready)
        begin
            req_reg.opt_byte   <= opt.opt_byte;
            req_reg.captured   <= opt.captured;
            req_reg.area_end   <= opt.area_end;
            req_reg.area_empty <= opt.area_empty;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.req   = req_reg;

`ifndef SYNTHESIS
    a_step_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> valid_reg)
        else $error("request consumed from an empty input register");
`endif

endmodule

@@ rtl/tcpo_parse.sv @@
`timescale 1ns / 1ps
// Option walker of the TCP option parser: kind/length/value state and the
// running summary of the current option area. Depends on tcpo_pkg.

module tcpo_parse
    import tcpo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  opt_slot_t slot,
    input  logic      step,
    output logic      emit,
    output opt_sum_t  sum
);

    localparam logic [1:0] PH_KIND  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        kind_reg, kind_next;
    logic [7:0]        len_reg, len_next;
    logic [5:0]        byte_pos_reg, byte_pos_next;
    logic [63:0]       val_reg, val_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              skip_reg, skip_next;
    logic [AREA_W-1:0] area_reg, area_next;
    opt_sum_t          sum_reg, sum_rec;

    logic              trunc;
    logic              rec_byte;
    logic              rec;
    logic              finish;
    logic [8:0]        len_round;
    logic [5:0]        blocks;

    always_comb
    begin
        phase_next    = phase_reg;
        kind_next     = kind_reg;
        len_next      = len_reg;
        byte_pos_next = byte_pos_reg;
        val_next      = val_reg;
        acc_next      = acc_reg;
        skip_next     = skip_reg;
        area_next     = area_reg;
        trunc         = 1'b0;
        rec_byte      = 1'b0;
        finish        = 1'b0;
        if (slot.req.area_empty)
        begin
            finish = 1'b1;
        end
        else
        begin
            area_next = area_reg + 1'b1;
            finish    = slot.req.area_end || (area_reg >= AREA_W'(MAX_OPTION_BYTES - 1));
            if (!skip_reg)
            begin
                if (!slot.req.captured)
                begin
                    trunc      = 1'b1;
                    skip_next  = 1'b1;
                    phase_next = PH_KIND;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_KIND:
                        begin
                            if (slot.req.opt_byte > KIND_NOP)
                            begin
                                kind_next  = slot.req.opt_byte;
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            if (slot.req.opt_byte == 8'd0)
                            begin
                                skip_next  = 1'b1;
                                phase_next = PH_KIND;
                            end
                            else
                            begin
                                len_next = slot.req.opt_byte;
                                val_next = '0;
                                acc_next = '0;
                                if (slot.req.opt_byte <= SACK_HDR_BYTES)
                                begin
                                    rec_byte   = 1'b1;
                                    phase_next = PH_KIND;
                                end
                                else
                                begin
                                    byte_pos_next = 6'd2;
                                    phase_next    = PH_VALUE;
                                end
                            end
                        end
                        PH_VALUE:
                        begin
                            if (acc_reg < ACC_W'(VALUE_BYTES))
                            begin
                                for (int i = 0; i < VALUE_BYTES; i++)
                                begin
                                    if (acc_reg == ACC_W'(i))
                                    begin
                                        val_next[63 - 8 * i -: 8] = slot.req.opt_byte;
                                    end
                                end
                                acc_next = acc_reg + 1'b1;
                            end
                            byte_pos_next = byte_pos_reg + 1'b1;
                            if ({2'b00, byte_pos_next} >= len_reg)
                            begin
                                rec_byte   = 1'b1;
                                phase_next = PH_KIND;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_KIND;
                        end
                    endcase
                end
            end
        end
    end

    // An area that ends inside a value still records what it has.
    assign rec = rec_byte || (finish && !skip_next && (phase_next == PH_VALUE));

    assign len_round = {1'b0, len_next} + 9'd5;

    always_comb
    begin
        blocks = '0;
        if (len_next > SACK_HDR_BYTES)
        begin
            blocks = len_round[8:3];
        end
        if (blocks > 6'(MAX_SACK_BLOCKS))
        begin
            blocks = 6'(MAX_SACK_BLOCKS);
        end
    end

    always_comb
    begin
        sum_rec = sum_reg;
        if (trunc)
        begin
            sum_rec.truncated = 1'b1;
        end
        if (rec)
        begin
            unique case (kind_next)
                KIND_MSS:
                begin
                    sum_rec.mss_value = val_next[63:48];
                    sum_rec.mss_seen  = 1'b1;
                end
                KIND_WSCALE:
                begin
                    sum_rec.wscale_value = val_next[63:56];
                    sum_rec.wscale_seen  = 1'b1;
                end
                KIND_TIMESTAMP:
                begin
                    sum_rec.ts_value = val_next[63:32];
                    sum_rec.ts_echo  = val_next[31:0];
                    sum_rec.ts_seen  = 1'b1;
                end
                KIND_SACK_OK:
                begin
                    sum_rec.sack_permitted = 1'b1;
                end
                KIND_SACK:
                begin
                    sum_rec.sack_blocks = blocks[2:0];
                    sum_rec.sack_seen   = 1'b1;
                end
                KIND_ECHO, KIND_ECHO_REPLY, KIND_CC, KIND_CC_NEW, KIND_CC_ECHO:
                begin
                    sum_rec.truncated = sum_rec.truncated;
                end
                default:
                begin
                    if (sum_reg.unknown_options != 6'h3F)
                    begin
                        sum_rec.unknown_options = sum_reg.unknown_options + 1'b1;
                    end
                end
            endcase
        end
    end

    assign emit = slot.valid && finish;
    assign sum  = sum_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_KIND;
            kind_reg     <= '0;
            len_reg      <= '0;
            byte_pos_reg <= '0;
            val_reg      <= '0;
            acc_reg      <= '0;
            skip_reg     <= 1'b0;
            area_reg     <= '0;
            sum_reg      <= '0;
        end
        else if (step)
        begin
            if (finish)
            begin
                phase_reg    <= PH_KIND;
                kind_reg     <= '0;
                len_reg      <= '0;
                byte_pos_reg <= '0;
                val_reg      <= '0;
                acc_reg      <= '0;
                skip_reg     <= 1'b0;
                area_reg     <= '0;
                sum_reg      <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                kind_reg     <= kind_next;
                len_reg      <= len_next;
                byte_pos_reg <= byte_pos_next;
                val_reg      <= val_next;
                acc_reg      <= acc_next;
                skip_reg     <= skip_next;
                area_reg     <= area_next;
                sum_reg      <= sum_rec;
            end
        end
    end

`ifndef SYNTHESIS
    a_area_bound: assert property (@(posedge clk) disable iff (!rst_n)
        area_reg < AREA_W'(MAX_OPTION_BYTES))
        else $error("option area byte count passed its limit");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= ACC_W'(VALUE_BYTES))
        else $error("value byte count passed its limit");

    a_skip_kind: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> (phase_reg == PH_KIND))
        else $error("skipping while inside an option");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> (area_reg == '0) && (sum_reg == '0) && !skip_reg)
        else $error("area state not cleared after a summary");
`endif

endmodule

@@ rtl/tcpo_out_stage.sv @@
`timescale 1ns / 1ps
// Result register of the TCP option parser: holds one summary until taken.
// Depends on tcpo_pkg and tcpo_sum_if.

module tcpo_out_stage
    import tcpo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  opt_sum_t    sum,
    output logic        room,
    tcpo_sum_if.source  summary
);

    logic     valid_reg;
    opt_sum_t data_reg;

    assign room = !valid_reg || summary.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (summary.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= sum;
        end
    end

    assign summary.valid           = valid_reg;
    assign summary.mss_value       = data_reg.mss_value;
    assign summary.mss_seen        = data_reg.mss_seen;
    assign summary.wscale_value    = data_reg.wscale_value;
    assign summary.wscale_seen     = data_reg.wscale_seen;
    assign summary.ts_value        = data_reg.ts_value;
    assign summary.ts_echo         = data_reg.ts_echo;
    assign summary.ts_seen         = data_reg.ts_seen;
    assign summary.sack_permitted  = data_reg.sack_permitted;
    assign summary.sack_blocks     = data_reg.sack_blocks;
    assign summary.sack_seen       = data_reg.sack_seen;
    assign summary.unknown_options = data_reg.unknown_options;
    assign summary.truncated       = data_reg.truncated;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || summary.ready))
        else $error("pending summary overwritten");
`endif

endmodule

@@ rtl/tcp_option_parser.sv @@
`timescale 1ns / 1ps
// Top level of the TCP option parser.
// Depends on tcpo_pkg, tcpo_if, tcpo_in_stage, tcpo_parse and tcpo_out_stage.
//
//   port      dir   carries
//   opt       in    one option byte request: opt_byte, captured, area_end, area_empty
//   summary   out   one summary per option area
//
// One request is taken every cycle while the summary side is not stalled.
// A request is parsed in the cycle after it is taken; its summary, if any, is
// held in the result register until taken. The input register and the result register
// part the two sides: a request that makes no summary always advances, and one
// that makes a summary waits only while a previous summary is still untaken.
// Reset clears the walker to the start of an option area with an empty summary.

module tcp_option_parser
    import tcpo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tcpo_opt_if.sink    opt,
    tcpo_sum_if.source  summary
);

    opt_slot_t slot;
    opt_sum_t  sum;
    logic      emit;
    logic      room;
    logic      step;
    logic      load;

    assign step = slot.valid && (!emit || room);
    assign load = step && emit;

    tcpo_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .opt   (opt),
        .step  (step),
        .slot  (slot)
    );

    tcpo_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .slot  (slot),
        .step  (step),
        .emit  (emit),
        .sum   (sum)
    );

    tcpo_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .sum     (sum),
        .room    (room),
        .summary (summary)
    );

endmodule
